// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of the gateway.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bbcg_pkg.sv =====
// Shared types, codes and constants of the brake booster command gateway.
// Used by the channel interfaces, the top level and the checker.
package bbcg_pkg;

  localparam int unsigned KindW     = 3;
  localparam int unsigned PayloadW  = 64;
  localparam int unsigned MailboxW  = 4;
  localparam int unsigned FlowW     = 16;
  localparam int unsigned FlagsW    = 3;
  localparam int unsigned FaultW    = 4;
  localparam int unsigned LinkW     = 3;
  localparam int unsigned SpeedCodeW = 14;
  localparam int unsigned SeqW      = 4;
  localparam int unsigned RodW      = 12;
  localparam int unsigned GainW     = 4;
  localparam int unsigned TimeoutW  = 8;
  localparam int unsigned SpeedW    = 8;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned RelCmdW   = 16;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // ceil(2^16 / 9); exact for the scaled speed range of 0 to 4080.
  localparam logic [12:0] SpeedRecip = 13'd7282;

  typedef enum logic [KindW-1:0] {
    KIND_COMMAND   = 3'd0,
    KIND_SPEED     = 3'd1,
    KIND_ROD       = 3'd2,
    KIND_STATUS    = 3'd3,
    KIND_TICK      = 3'd4,
    KIND_BUS_ERROR = 3'd5
  } bbcg_kind_e;

  typedef enum logic [FaultW-1:0] {
    FAULT_NONE         = 4'd0,
    FAULT_CHECKSUM     = 4'd1,
    FAULT_STATUS_SEND  = 4'd2,
    FAULT_BUS          = 4'd3,
    FAULT_POWER_ON     = 4'd4,
    FAULT_CMD_STALE    = 4'd5,
    FAULT_MODE         = 4'd6,
    FAULT_SEQ_MISMATCH = 4'd7,
    FAULT_CTL0_SEND    = 4'd8,
    FAULT_CTL1_SEND    = 4'd9,
    FAULT_SPEED_SEND   = 4'd10
  } bbcg_fault_e;

  typedef enum logic [LinkW-1:0] {
    LINK_NONE           = 3'd0,
    LINK_ROD_CHECKSUM   = 3'd1,
    LINK_STATUS_CHECKSUM = 3'd2,
    LINK_ROD_COUNTER    = 3'd3,
    LINK_STATUS_COUNTER = 3'd4
  } bbcg_link_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_POSITION_GAIN = 3'd0,
    REG_FLOW_ZERO     = 3'd1,
    REG_FLOW_MAX      = 3'd2,
    REG_FLOW_MIN      = 3'd3,
    REG_TIMEOUT_LIMIT = 3'd4,
    REG_ROD_THRESHOLD = 3'd5
  } bbcg_reg_e;

  typedef struct packed {
    logic [GainW-1:0]    position_gain;
    logic [FlowW-1:0]    flow_zero;
    logic [FlowW-1:0]    flow_max;
    logic [FlowW-1:0]    flow_min;
    logic [TimeoutW-1:0] timeout_limit;
    logic [RodW-1:0]     rod_brake_threshold;
  } bbcg_cfg_t;

  localparam bbcg_cfg_t CfgReset = '{
    position_gain:       4'd2,
    flow_zero:           16'h7E00,
    flow_max:            16'h9200,
    flow_min:            16'h6A00,
    timeout_limit:       8'd50,
    rod_brake_threshold: 12'h23F
  };

  typedef struct packed {
    logic [FlowW-1:0]      flow_target;
    logic                  flow_valid;
    logic                  relay_on;
    logic [FlagsW-1:0]     brake_flags;
    logic [FaultW-1:0]     fault_code;
    logic [LinkW-1:0]      link_fault;
    logic [SpeedCodeW-1:0] speed_code;
    logic [SeqW-1:0]       control_seq;
    logic [SeqW-1:0]       speed_seq;
    logic [SeqW-1:0]       status_seq;
    logic [MailboxW-1:0]   sent_mask;
    logic [RodW-1:0]       rod_position;
  } bbcg_result_t;

  // Speed times 16 over 9, done as a multiply by the scaled reciprocal.
  function automatic logic [SpeedCodeW-1:0] speed_code_f(input logic [SpeedW-1:0] spd);
    logic [SpeedW+3:0] scaled;
    logic [24:0]       prod;
    scaled = {spd, 4'b0000};
    prod   = 25'(scaled) * 25'(SpeedRecip);
    return SpeedCodeW'(prod[24:16]);
  endfunction

endpackage

// ===== rtl/bbcg_channels.sv =====
// Valid/ready channel interfaces of the gateway: input items, results and
// configuration writes. Depends on bbcg_pkg for the field widths.
interface bbcg_in_if import bbcg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [PayloadW-1:0] payload;
  logic                checksum_ok;
  logic [MailboxW-1:0] mailbox_free;

  modport source (output valid, kind, payload, checksum_ok, mailbox_free, input ready);
  modport sink   (input valid, kind, payload, checksum_ok, mailbox_free, output ready);
endinterface

interface bbcg_out_if import bbcg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FlowW-1:0]      flow_target;
  logic                  flow_valid;
  logic                  relay_on;
  logic [FlagsW-1:0]     brake_flags;
  logic [FaultW-1:0]     fault_code;
  logic [LinkW-1:0]      link_fault;
  logic [SpeedCodeW-1:0] speed_code;
  logic [SeqW-1:0]       control_seq;
  logic [SeqW-1:0]       speed_seq;
  logic [SeqW-1:0]       status_seq;
  logic [MailboxW-1:0]   sent_mask;
  logic [RodW-1:0]       rod_position;

  modport source (
    output valid, flow_target, flow_valid, relay_on, brake_flags, fault_code, link_fault,
           speed_code, control_seq, speed_seq, status_seq, sent_mask, rod_position,
    input  ready
  );
  modport sink (
    input  valid, flow_target, flow_valid, relay_on, brake_flags, fault_code, link_fault,
           speed_code, control_seq, speed_seq, status_seq, sent_mask, rod_position,
    output ready
  );
endinterface

interface bbcg_cfg_if import bbcg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/brake_booster_command_gateway_top.sv =====
// A tick's result passes the input register, then the result register, and is
// presented from the result register; other kinds give no result.
// Throughput: one item per cycle; input ready drops only while a tick waits in
// the input register behind a result that has not been taken.
// Reset (rst_ni low, asynchronous): state, config and valid registers reset,
// fault state startup, no result pending. No clearing pass is needed.
module brake_booster_command_gateway_top import bbcg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  bbcg_in_if.sink  in_ch,
  bbcg_out_if.source out_ch,
  bbcg_cfg_if.sink cfg_ch
);

  typedef struct packed {
    logic                pos_mode;
    logic                rel_mode;
    logic [RodW-1:0]     pos_cmd;
    logic [RelCmdW-1:0]  rel_cmd;
    logic [RodW-1:0]     rod;
    logic [SpeedW-1:0]   speed;
    logic [StatusW-1:0]  booster_status;
    logic                driver_braking;
    logic                brk_engaged;
    logic [FaultW-1:0]   fault;
    logic [LinkW-1:0]    link;
    logic [TimeoutW-1:0] idle_ticks;
    logic [SeqW-1:0]     cmd_seq_in;
    logic [SeqW-1:0]     rod_seq_in;
    logic [SeqW-1:0]     sts_seq_in;
    logic [SeqW-1:0]     ctl_seq_out;
    logic [SeqW-1:0]     spd_seq_out;
    logic [SeqW-1:0]     sts_seq_out;
    logic                speed_phase;
  } state_t;

  localparam state_t StateReset = '{
    fault:   FAULT_POWER_ON,
    link:    LINK_NONE,
    default: '0
  };

  bbcg_cfg_t cfg_q;
  state_t    st_q, st_d;

  logic                s1_valid_q;
  logic [KindW-1:0]    s1_kind_q;
  logic [PayloadW-1:0] s1_payload_q;
  logic                s1_ok_q;
  logic [MailboxW-1:0] s1_mb_q;

  logic         out_valid_q;
  bbcg_result_t out_res_q;
  bbcg_result_t res_tick;

  logic s1_is_tick, s1_fire, tick_fire, in_acc;

  // Input stage and result register handshake.
  assign s1_is_tick  = (s1_kind_q == KIND_TICK);
  assign s1_fire     = s1_valid_q && (!s1_is_tick || !out_valid_q || out_ch.ready);
  assign tick_fire   = s1_fire && s1_is_tick;
  assign in_ch.ready = !s1_valid_q || s1_fire;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (tick_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q    <= in_ch.kind;
      s1_payload_q <= in_ch.payload;
      s1_ok_q      <= in_ch.checksum_ok;
      s1_mb_q      <= in_ch.mailbox_free;
    end
    if (tick_fire) begin
      out_res_q <= res_tick;
    end
  end

  // Configuration registers; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (bbcg_reg_e'(cfg_ch.index))
        REG_POSITION_GAIN: cfg_q.position_gain       <= cfg_ch.data[GainW-1:0];
        REG_FLOW_ZERO:     cfg_q.flow_zero           <= cfg_ch.data;
        REG_FLOW_MAX:      cfg_q.flow_max            <= cfg_ch.data;
        REG_FLOW_MIN:      cfg_q.flow_min            <= cfg_ch.data;
        REG_TIMEOUT_LIMIT: cfg_q.timeout_limit       <= cfg_ch.data[TimeoutW-1:0];
        REG_ROD_THRESHOLD: cfg_q.rod_brake_threshold <= cfg_ch.data[RodW-1:0];
        default: ;
      endcase
    end
  end

  // Position loop: zero + (command - rod) * gain, clamped; the lower clamp wins.
  logic signed [12:0] pos_err;
  logic signed [17:0] err_ext, gain_ext, prod, sum, max_ext, min_ext, clamp_hi;
  logic [FlowW-1:0]   pos_flow;

  always_comb begin
    pos_err  = $signed({1'b0, st_q.pos_cmd}) - $signed({1'b0, st_q.rod});
    err_ext  = {{5{pos_err[12]}}, pos_err};
    gain_ext = {14'b0, cfg_q.position_gain};
    prod     = err_ext * gain_ext;
    sum      = prod + $signed({2'b00, cfg_q.flow_zero});
    max_ext  = $signed({2'b00, cfg_q.flow_max});
    min_ext  = $signed({2'b00, cfg_q.flow_min});
    clamp_hi = (sum > max_ext) ? max_ext : sum;
    pos_flow = (clamp_hi < min_ext) ? cfg_q.flow_min : clamp_hi[FlowW-1:0];
  end

  logic [7:0]       byte1, byte2;
  logic [SeqW-1:0]  rx_seq;
  logic             mode_pos, mode_rel, timeout_hit, spd_slot;
  logic [FlowW-1:0] sent_flow;
  logic             sent_valid, drv_brake_new;

  always_comb begin
    byte1       = s1_payload_q[15:8];
    byte2       = s1_payload_q[23:16];
    rx_seq      = byte1[SeqW-1:0];
    mode_pos    = st_q.pos_mode && !st_q.rel_mode;
    mode_rel    = st_q.rel_mode && !st_q.pos_mode;
    timeout_hit = (st_q.idle_ticks == cfg_q.timeout_limit);
    spd_slot    = !st_q.speed_phase;
    drv_brake_new = byte2[0] | ~byte2[1];

    if (mode_pos) begin
      sent_flow  = pos_flow;
      sent_valid = 1'b1;
    end else if (mode_rel) begin
      sent_flow  = st_q.rel_cmd;
      sent_valid = 1'b1;
    end else begin
      sent_flow  = cfg_q.flow_zero;
      sent_valid = 1'b0;
    end
    if (st_q.driver_braking) begin
      sent_flow  = cfg_q.flow_zero;
      sent_valid = 1'b0;
    end

    st_d = st_q;
    if (s1_fire) begin
      case (bbcg_kind_e'(s1_kind_q))
        KIND_COMMAND: begin
          if (s1_ok_q) begin
            if (st_q.cmd_seq_in + 4'd1 == rx_seq) begin
              st_d.pos_mode   = byte1[5];
              st_d.rel_mode   = byte1[4];
              st_d.pos_cmd    = {s1_payload_q[43:40], s1_payload_q[39:32]};
              st_d.rel_cmd    = s1_payload_q[31:16];
              st_d.cmd_seq_in = st_q.cmd_seq_in + 4'd1;
              st_d.fault      = FAULT_NONE;
            end else begin
              // The counter fault stays; the timeout count still restarts.
              st_d.fault = FAULT_SEQ_MISMATCH;
            end
            st_d.idle_ticks = '0;
          end else begin
            st_d.fault = FAULT_CHECKSUM;
          end
        end
        KIND_SPEED: begin
          if (s1_ok_q) begin
            st_d.speed = s1_payload_q[31:24];
          end else begin
            st_d.fault = FAULT_CHECKSUM;
          end
        end
        KIND_ROD: begin
          if (s1_ok_q) begin
            if (st_q.rod_seq_in + 4'd1 == rx_seq) begin
              st_d.rod        = {s1_payload_q[35:32], s1_payload_q[31:24]};
              st_d.rod_seq_in = st_q.rod_seq_in + 4'd1;
            end else begin
              st_d.link = LINK_ROD_COUNTER;
            end
          end else begin
            st_d.link = LINK_ROD_CHECKSUM;
          end
        end
        KIND_STATUS: begin
          if (s1_ok_q) begin
            if (st_q.sts_seq_in + 4'd1 == rx_seq) begin
              st_d.booster_status = s1_payload_q[21:19];
              st_d.driver_braking = drv_brake_new;
              st_d.brk_engaged    = drv_brake_new ||
                                    (st_q.rod > cfg_q.rod_brake_threshold);
              st_d.sts_seq_in     = st_q.sts_seq_in + 4'd1;
            end else begin
              st_d.link = LINK_STATUS_COUNTER;
            end
          end else begin
            st_d.link = LINK_STATUS_CHECKSUM;
          end
        end
        KIND_TICK: begin
          // Later causes overwrite earlier ones, so the last one listed wins.
          if (!mode_pos && !mode_rel) begin
            st_d.fault    = FAULT_MODE;
            st_d.pos_mode = 1'b0;
            st_d.rel_mode = 1'b0;
          end
          if (!s1_mb_q[0]) st_d.fault = FAULT_CTL0_SEND;
          if (!s1_mb_q[1]) st_d.fault = FAULT_CTL1_SEND;
          if (spd_slot && !s1_mb_q[2]) st_d.fault = FAULT_SPEED_SEND;
          if (!s1_mb_q[3]) st_d.fault = FAULT_STATUS_SEND;
          st_d.ctl_seq_out = st_q.ctl_seq_out + SeqW'(s1_mb_q[1]);
          st_d.spd_seq_out = st_q.spd_seq_out + SeqW'(spd_slot && s1_mb_q[2]);
          st_d.sts_seq_out = st_q.sts_seq_out + SeqW'(s1_mb_q[3]);
          st_d.speed_phase = !st_q.speed_phase;
          if (timeout_hit) begin
            st_d.fault    = FAULT_CMD_STALE;
            st_d.pos_mode = 1'b0;
            st_d.rel_mode = 1'b0;
          end else begin
            st_d.idle_ticks = st_q.idle_ticks + 8'd1;
          end
        end
        KIND_BUS_ERROR: st_d.fault = FAULT_BUS;
        default: ;
      endcase
    end

    res_tick.flow_target  = sent_flow;
    res_tick.flow_valid   = sent_valid;
    res_tick.relay_on     = st_q.brk_engaged;
    res_tick.brake_flags  = {st_q.brk_engaged, st_q.driver_braking,
                             (st_q.booster_status == 3'd7)};
    res_tick.fault_code   = st_d.fault;
    res_tick.link_fault   = st_q.link;
    res_tick.speed_code   = speed_code_f(st_q.speed);
    res_tick.control_seq  = st_q.ctl_seq_out;
    res_tick.speed_seq    = st_q.spd_seq_out;
    res_tick.status_seq   = st_q.sts_seq_out;
    res_tick.sent_mask    = {s1_mb_q[3], spd_slot && s1_mb_q[2], s1_mb_q[1], s1_mb_q[0]};
    res_tick.rod_position = st_q.rod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StateReset;
    end else begin
      st_q <= st_d;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.flow_target  = out_res_q.flow_target;
  assign out_ch.flow_valid   = out_res_q.flow_valid;
  assign out_ch.relay_on     = out_res_q.relay_on;
  assign out_ch.brake_flags  = out_res_q.brake_flags;
  assign out_ch.fault_code   = out_res_q.fault_code;
  assign out_ch.link_fault   = out_res_q.link_fault;
  assign out_ch.speed_code   = out_res_q.speed_code;
  assign out_ch.control_seq  = out_res_q.control_seq;
  assign out_ch.speed_seq    = out_res_q.speed_seq;
  assign out_ch.status_seq   = out_res_q.status_seq;
  assign out_ch.sent_mask    = out_res_q.sent_mask;
  assign out_ch.rod_position = out_res_q.rod_position;

endmodule

// ===== rtl/bbcg_checker.sv =====
// Port-level checker of the gateway and the bind that attaches it.
// Depends on bbcg_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module bbcg_checker import bbcg_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [FlowW-1:0]    flow_target_i,
  input logic                relay_on_i,
  input logic [FlagsW-1:0]   brake_flags_i,
  input logic [FaultW-1:0]   fault_code_i,
  input logic [LinkW-1:0]    link_fault_i,
  input logic [SeqW-1:0]     control_seq_i,
  input logic [MailboxW-1:0] sent_mask_i
);

  logic            out_acc;
  logic            seen_q;
  logic [SeqW-1:0] exp_ctl_q;

  assign out_acc = out_valid_i && out_ready_i;

  // The control counter advances only when the second control frame went out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 1'b0;
      exp_ctl_q <= '0;
    end else if (out_acc) begin
      seen_q    <= 1'b1;
      exp_ctl_q <= control_seq_i + SeqW'(sent_mask_i[1]);
    end
  end

  `ASSERT_NEXT(out_hold_a, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({flow_target_i, fault_code_i, control_seq_i}), "result changed while stalled")
  `ASSERT_IMPLIES(relay_a, clk_i, rst_ni, out_valid_i, relay_on_i == brake_flags_i[2], "relay differs from brake applied flag")
  `ASSERT_IMPLIES(codes_a, clk_i, rst_ni, out_valid_i, (fault_code_i <= FAULT_SPEED_SEND) && (link_fault_i <= LINK_STATUS_COUNTER), "fault or link code out of range")
  `ASSERT_IMPLIES(ctl_seq_a, clk_i, rst_ni, out_acc && seen_q, control_seq_i == exp_ctl_q, "control sequence number skipped or repeated")

endmodule

bind brake_booster_command_gateway_top bbcg_checker u_bbcg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .flow_target_i (out_ch.flow_target),
  .relay_on_i    (out_ch.relay_on),
  .brake_flags_i (out_ch.brake_flags),
  .fault_code_i  (out_ch.fault_code),
  .link_fault_i  (out_ch.link_fault),
  .control_seq_i (out_ch.control_seq),
  .sent_mask_i   (out_ch.sent_mask)
);

// ===== verif/bbcg_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard of the brake booster command gateway: keeps its own copy of the
// gateway state, predicts every tick result and compares it field by field.
// Depends on bbcg_pkg and the channel interfaces of bbcg_channels.sv.
module bbcg_scoreboard import bbcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbcg_in_if          in_ch,
  bbcg_out_if         out_ch,
  bbcg_cfg_if         cfg_ch,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  bbcg_cfg_t            regs;
  logic                 pos_mode;
  logic                 rel_mode;
  logic [RodW-1:0]      pos_cmd;
  logic [RelCmdW-1:0]   rel_cmd;
  logic [RodW-1:0]      rod;
  logic [SpeedW-1:0]    speed;
  logic [StatusW-1:0]   boost_st;
  logic                 drv_brake;
  logic                 applied;
  logic [FlowW-1:0]     flow;
  logic                 flow_on;
  logic [FaultW-1:0]    fault;
  logic [LinkW-1:0]     link;
  logic [TimeoutW-1:0]  idle_ticks;
  logic [SeqW-1:0]      cmd_seq;
  logic [SeqW-1:0]      rod_seq;
  logic [SeqW-1:0]      sts_seq;
  logic [SeqW-1:0]      ctl_out;
  logic [SeqW-1:0]      spd_out;
  logic [SeqW-1:0]      sts_out;
  logic                 spd_phase;

  bbcg_result_t tick_results_q[$];
  int unsigned  result_idx;
  string        diff_text;

  function automatic void clear_state();
    regs       = CfgReset;
    pos_mode   = 1'b0;
    rel_mode   = 1'b0;
    pos_cmd    = '0;
    rel_cmd    = '0;
    rod        = '0;
    speed      = '0;
    boost_st   = '0;
    drv_brake  = 1'b0;
    applied    = 1'b0;
    flow       = CfgReset.flow_zero;
    flow_on    = 1'b0;
    fault      = FAULT_POWER_ON;
    link       = LINK_NONE;
    idle_ticks = '0;
    cmd_seq    = '0;
    rod_seq    = '0;
    sts_seq    = '0;
    ctl_out    = '0;
    spd_out    = '0;
    sts_out    = '0;
    spd_phase  = 1'b0;
  endfunction

  function automatic void go_neutral();
    flow_on = 1'b0;
    flow    = regs.flow_zero;
  endfunction

  function automatic void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_POSITION_GAIN: regs.position_gain       = data[GainW-1:0];
      REG_FLOW_ZERO:     regs.flow_zero           = data;
      REG_FLOW_MAX:      regs.flow_max            = data;
      REG_FLOW_MIN:      regs.flow_min            = data;
      REG_TIMEOUT_LIMIT: regs.timeout_limit       = data[TimeoutW-1:0];
      REG_ROD_THRESHOLD: regs.rod_brake_threshold = data[RodW-1:0];
      default: ;
    endcase
  endfunction

  function automatic bbcg_result_t tick_result(logic [MailboxW-1:0] free);
    bbcg_result_t r;
    int           err;
    int           tgt;
    logic [3:0]   sent;
    r    = '0;
    sent = '0;
    if (pos_mode && !rel_mode) begin
      err = int'(pos_cmd) - int'(rod);
      tgt = int'(regs.flow_zero) + err * int'(regs.position_gain);
      if (tgt > int'(regs.flow_max)) tgt = int'(regs.flow_max);
      // With crossed limits the lower clamp is applied last and wins.
      if (tgt < int'(regs.flow_min)) tgt = int'(regs.flow_min);
      flow_on = 1'b1;
      flow    = tgt[FlowW-1:0];
    end else if (rel_mode && !pos_mode) begin
      flow_on = 1'b1;
      flow    = rel_cmd;
    end else begin
      go_neutral();
      pos_mode = 1'b0;
      rel_mode = 1'b0;
      fault    = FAULT_MODE;
    end
    if (drv_brake) go_neutral();

    r.control_seq = ctl_out;
    r.flow_target = flow;
    r.flow_valid  = flow_on;
    if (free[0]) sent[0] = 1'b1;
    else fault = FAULT_CTL0_SEND;
    if (free[1]) begin
      sent[1] = 1'b1;
      ctl_out++;
    end else begin
      fault = FAULT_CTL1_SEND;
    end
    r.speed_seq = spd_out;
    if (!spd_phase) begin
      if (free[2]) begin
        sent[2] = 1'b1;
        spd_out++;
      end else begin
        fault = FAULT_SPEED_SEND;
      end
    end
    spd_phase   = ~spd_phase;
    r.status_seq = sts_out;
    if (free[3]) begin
      sent[3] = 1'b1;
      sts_out++;
    end else begin
      fault = FAULT_STATUS_SEND;
    end

    // The flow target reported for this tick is the one captured above.
    if (idle_ticks == regs.timeout_limit) begin
      fault = FAULT_CMD_STALE;
      go_neutral();
      pos_mode = 1'b0;
      rel_mode = 1'b0;
    end else begin
      idle_ticks++;
    end

    r.relay_on     = applied;
    r.brake_flags  = {applied, drv_brake, boost_st == 3'd7};
    r.fault_code   = fault;
    r.link_fault   = link;
    r.speed_code   = SpeedCodeW'((int'(speed) * 16) / 9);
    r.sent_mask    = sent;
    r.rod_position = rod;
    return r;
  endfunction

  function automatic void take_item(logic [KindW-1:0] kind, logic [PayloadW-1:0] p,
                                    logic ok, logic [MailboxW-1:0] free);
    logic [SeqW-1:0] seq;
    logic [7:0]      b2;
    seq = p[11:8];
    b2  = p[23:16];
    case (kind)
      KIND_COMMAND: begin
        if (ok) begin
          if (SeqW'(cmd_seq + 1) == seq) begin
            pos_mode = p[13];
            rel_mode = p[12];
            pos_cmd  = {p[43:40], p[39:32]};
            rel_cmd  = p[31:16];
            cmd_seq++;
            fault    = FAULT_NONE;
          end else begin
            // A counter mismatch keeps its own code; the timeout still clears.
            fault = FAULT_SEQ_MISMATCH;
          end
          idle_ticks = '0;
        end else begin
          fault = FAULT_CHECKSUM;
        end
      end
      KIND_SPEED: begin
        if (ok) speed = p[31:24];
        else fault = FAULT_CHECKSUM;
      end
      KIND_ROD: begin
        if (!ok) link = LINK_ROD_CHECKSUM;
        else if (SeqW'(rod_seq + 1) != seq) link = LINK_ROD_COUNTER;
        else begin
          rod = {p[35:32], p[31:24]};
          rod_seq++;
        end
      end
      KIND_STATUS: begin
        if (!ok) link = LINK_STATUS_CHECKSUM;
        else if (SeqW'(sts_seq + 1) != seq) link = LINK_STATUS_COUNTER;
        else begin
          boost_st  = p[21:19];
          drv_brake = b2[0] | ~b2[1];
          applied   = drv_brake | (rod > regs.rod_brake_threshold);
          sts_seq++;
        end
      end
      KIND_TICK:      tick_results_q.push_back(tick_result(free));
      KIND_BUS_ERROR: fault = FAULT_BUS;
      default: ;
    endcase
  endfunction

  function automatic void flag_error(string msg);
    error_count_o++;
    if (error_count_o <= 10) $display("[%0t] tick result %0d:%s", $realtime, result_idx, msg);
  endfunction

  function automatic void cmp(string name, logic [15:0] e, logic [15:0] a);
    if (a !== e) diff_text = {diff_text, $sformatf(" %s exp 0x%0h got 0x%0h", name, e, a)};
  endfunction

  function automatic void check_result();
    bbcg_result_t want;
    if (tick_results_q.size() == 0) begin
      flag_error($sformatf(" result with no tick waiting, flow 0x%0h fault %0d",
                           out_ch.flow_target, out_ch.fault_code));
    end else begin
      want      = tick_results_q.pop_front();
      diff_text = "";
      cmp("flow_target",  want.flow_target,  out_ch.flow_target);
      cmp("flow_valid",   want.flow_valid,   out_ch.flow_valid);
      cmp("relay_on",     want.relay_on,     out_ch.relay_on);
      cmp("brake_flags",  want.brake_flags,  out_ch.brake_flags);
      cmp("fault_code",   want.fault_code,   out_ch.fault_code);
      cmp("link_fault",   want.link_fault,   out_ch.link_fault);
      cmp("speed_code",   want.speed_code,   out_ch.speed_code);
      cmp("control_seq",  want.control_seq,  out_ch.control_seq);
      cmp("speed_seq",    want.speed_seq,    out_ch.speed_seq);
      cmp("status_seq",   want.status_seq,   out_ch.status_seq);
      cmp("sent_mask",    want.sent_mask,    out_ch.sent_mask);
      cmp("rod_position", want.rod_position, out_ch.rod_position);
      if (diff_text != "") flag_error(diff_text);
    end
    result_idx++;
  endfunction

  // The result transaction is handled first so that a tick taken in the same
  // cycle can never be matched against it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      tick_results_q.delete();
      error_count_o = 0;
      result_idx    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (cfg_ch.valid && cfg_ch.ready) write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        take_item(in_ch.kind, in_ch.payload, in_ch.checksum_ok, in_ch.mailbox_free);
      end
    end
    pending_o = tick_results_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the gateway testbench: clock, reset, frame and tick stimulus,
// register phases and the verdict. Depends on bbcg_pkg, the channel
// interfaces, the gateway top level and bbcg_scoreboard.
module tb_top;
  import bbcg_pkg::*;

  localparam int unsigned PhaseItems   = 228;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StuckLimit   = 4000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxGap       = 60;

  // Mode bits of a command frame, position bit first.
  localparam logic [1:0] ModeNone = 2'b00;
  localparam logic [1:0] ModeRel  = 2'b01;
  localparam logic [1:0] ModePos  = 2'b10;
  localparam logic [1:0] ModeBoth = 2'b11;

  logic clk_i;
  logic rst_ni;

  bbcg_in_if  in_ch();
  bbcg_out_if out_ch();
  bbcg_cfg_if cfg_ch();

  int unsigned error_count;
  int unsigned pending;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_req;
  int unsigned stuck_cycles;

  // Next sequence numbers the gateway will take, tracked from the stimulus.
  logic [SeqW-1:0] cmd_next;
  logic [SeqW-1:0] rod_next;
  logic [SeqW-1:0] sts_next;
  logic [RodW-1:0] last_rod;

  brake_booster_command_gateway_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bbcg_scoreboard u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever hold_req moves.
  initial begin : result_side
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [PayloadW-1:0] cmd_frame(logic [SeqW-1:0] seq, logic [1:0] mode,
                                                    logic [RodW-1:0] pcmd,
                                                    logic [RelCmdW-1:0] rcmd);
    logic [PayloadW-1:0] p;
    p        = {$urandom, $urandom};
    p[11:8]  = seq;
    p[13:12] = mode;
    p[31:16] = rcmd;
    p[39:32] = pcmd[7:0];
    p[43:40] = pcmd[11:8];
    return p;
  endfunction

  function automatic logic [PayloadW-1:0] rod_frame(logic [SeqW-1:0] seq, logic [RodW-1:0] pos);
    logic [PayloadW-1:0] p;
    p        = {$urandom, $urandom};
    p[11:8]  = seq;
    p[31:24] = pos[7:0];
    p[35:32] = pos[11:8];
    return p;
  endfunction

  function automatic logic [PayloadW-1:0] sts_frame(logic [SeqW-1:0] seq, logic [7:0] b2);
    logic [PayloadW-1:0] p;
    p        = {$urandom, $urandom};
    p[11:8]  = seq;
    p[23:16] = b2;
    return p;
  endfunction

  // Starts and ends right after a rising edge; valid is raised only once per step.
  task automatic put_item(input logic [KindW-1:0] kind, input logic [PayloadW-1:0] p,
                          input logic ok, input logic [MailboxW-1:0] free);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.payload      <= p;
    in_ch.checksum_ok  <= ok;
    in_ch.mailbox_free <= free;
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    if (ok) begin
      if (kind == KIND_COMMAND && p[11:8] == cmd_next) cmd_next++;
      if (kind == KIND_ROD && p[11:8] == rod_next) begin
        rod_next++;
        last_rod = {p[35:32], p[31:24]};
      end
      if (kind == KIND_STATUS && p[11:8] == sts_next) sts_next++;
    end
  endtask

  task automatic put_random();
    int unsigned         pick;
    int unsigned         mpick;
    logic                ok;
    logic [SeqW-1:0]     seq;
    logic [1:0]          mode;
    logic [RodW-1:0]     pcmd;
    logic [7:0]          b2;
    logic [MailboxW-1:0] free;
    pick = $urandom_range(99);
    ok   = ($urandom_range(99) >= 4);
    free = ($urandom_range(99) < 80) ? 4'hF : MailboxW'($urandom);
    if (pick < 30) begin
      put_item(KIND_TICK, {$urandom, $urandom}, ok, free);
    end else if (pick < 55) begin
      seq   = ($urandom_range(99) < 92) ? cmd_next : SeqW'($urandom);
      mpick = $urandom_range(9);
      mode  = (mpick < 4) ? ModePos : (mpick < 8) ? ModeRel : (mpick == 8) ? ModeNone : ModeBoth;
      // Half the position commands sit near the rod so that the loop leaves the clamps.
      pcmd  = $urandom_range(1) ? RodW'($urandom) : last_rod ^ RodW'($urandom_range(63));
      put_item(KIND_COMMAND, cmd_frame(seq, mode, pcmd, RelCmdW'($urandom)), ok, free);
    end else if (pick < 65) begin
      put_item(KIND_SPEED, {$urandom, $urandom}, ok, free);
    end else if (pick < 77) begin
      seq = ($urandom_range(99) < 92) ? rod_next : SeqW'($urandom);
      put_item(KIND_ROD, rod_frame(seq, RodW'($urandom)), ok, free);
    end else if (pick < 89) begin
      seq = ($urandom_range(99) < 92) ? sts_next : SeqW'($urandom);
      b2  = 8'($urandom);
      if ($urandom_range(3) != 0) b2[1:0] = 2'b10;
      put_item(KIND_STATUS, sts_frame(seq, b2), ok, free);
    end else if (pick < 95) begin
      put_item(KIND_BUS_ERROR, {$urandom, $urandom}, ok, free);
    end else begin
      put_item(KindW'($urandom_range(6, 7)), {$urandom, $urandom}, ok, free);
    end
  endtask

  task automatic write_reg(input bbcg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(negedge clk_i);
    while (!cfg_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic load_cfg(input bbcg_cfg_t c);
    write_reg(REG_POSITION_GAIN, CfgDataW'(c.position_gain));
    write_reg(REG_FLOW_ZERO, c.flow_zero);
    write_reg(REG_FLOW_MAX, c.flow_max);
    write_reg(REG_FLOW_MIN, c.flow_min);
    write_reg(REG_TIMEOUT_LIMIT, CfgDataW'(c.timeout_limit));
    write_reg(REG_ROD_THRESHOLD, CfgDataW'(c.rod_brake_threshold));
    cfg_ch.valid <= 1'b0;
  endtask

  // Holds the input until every tick result is back, then lets the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    bbcg_cfg_t       c;
    logic [FlowW-1:0] a;
    logic [FlowW-1:0] b;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = '0;
    in_ch.payload      = '0;
    in_ch.checksum_ok  = 1'b0;
    in_ch.mailbox_free = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    idle_pct           = 0;
    stall_pct          = 0;
    hold_req           = 0;
    cmd_next           = 4'd1;
    rod_next           = 4'd1;
    sts_next           = 4'd1;
    last_rod           = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);
    load_cfg(CfgReset);

    // Directed part: clamps, both modes, checksum, sequence, bus and send faults, all link faults.
    put_item(KIND_TICK, '0, 1'b1, 4'hF);
    put_item(KIND_COMMAND, cmd_frame(4'd1, ModePos, 12'hFFF, 16'h0000), 1'b1, 4'h0);
    put_item(KIND_ROD, rod_frame(4'd1, 12'h000), 1'b1, 4'h0);
    put_item(KIND_TICK, '1, 1'b0, 4'hF);
    put_item(KIND_COMMAND, cmd_frame(4'd2, ModePos, 12'h000, 16'h0000), 1'b1, 4'h0);
    put_item(KIND_ROD, rod_frame(4'd2, 12'hFFF), 1'b1, 4'h0);
    put_item(KIND_TICK, '0, 1'b1, 4'hF);
    put_item(KIND_COMMAND, cmd_frame(4'd3, ModeRel, 12'h000, 16'hFFFF), 1'b1, 4'h0);
    put_item(KIND_TICK, '0, 1'b1, 4'h0);
    put_item(KIND_COMMAND, cmd_frame(4'd9, ModePos, 12'h800, 16'h1234), 1'b1, 4'h0);
    put_item(KIND_TICK, '0, 1'b1, 4'hF);
    put_item(KIND_COMMAND, cmd_frame(4'd4, ModePos, 12'h800, 16'h1234), 1'b0, 4'h0);
    put_item(KIND_COMMAND, cmd_frame(4'd4, ModeBoth, 12'h800, 16'h1234), 1'b1, 4'h0);
    put_item(KIND_TICK, '0, 1'b1, 4'b0101);
    put_item(KIND_SPEED, '1, 1'b1, 4'h0);
    put_item(KIND_SPEED, '0, 1'b0, 4'h0);
    put_item(KIND_ROD, rod_frame(4'd3, 12'h123), 1'b0, 4'h0);
    put_item(KIND_ROD, rod_frame(4'd7, 12'h123), 1'b1, 4'h0);
    put_item(KIND_STATUS, sts_frame(4'd1, 8'h3A), 1'b0, 4'h0);
    put_item(KIND_STATUS, sts_frame(4'd5, 8'h3A), 1'b1, 4'h0);
    put_item(KIND_STATUS, sts_frame(4'd1, 8'b0011_1001), 1'b1, 4'h0);
    put_item(KIND_TICK, '0, 1'b1, 4'hF);
    put_item(KIND_BUS_ERROR, '1, 1'b1, 4'hF);
    put_item(3'd6, '0, 1'b1, 4'h0);
    put_item(3'd7, '1, 1'b1, 4'hF);
    put_item(KIND_TICK, '1, 1'b1, 4'hA);
    drain();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: c = CfgReset;
        1: c = '{position_gain: 4'd15, flow_zero: 16'h8000, flow_max: 16'hFFFF,
                 flow_min: 16'h0000, timeout_limit: 8'd255, rod_brake_threshold: 12'h000};
        // Crossed clamp limits with a timeout limit of one.
        2: c = '{position_gain: 4'd0, flow_zero: 16'h0000, flow_max: 16'h0000,
                 flow_min: 16'hFFFF, timeout_limit: 8'd1, rod_brake_threshold: 12'hFFF};
        // A zero timeout limit fires on the first tick after every command.
        3: c = '{position_gain: 4'd1, flow_zero: 16'hFFFF, flow_max: 16'h9000,
                 flow_min: 16'h7000, timeout_limit: 8'd0, rod_brake_threshold: 12'h23F};
        default: begin
          a = FlowW'($urandom);
          b = FlowW'($urandom);
          c.position_gain       = GainW'($urandom);
          c.flow_zero           = FlowW'($urandom);
          c.flow_max            = ((a > b) == ($urandom_range(3) != 0)) ? a : b;
          c.flow_min            = (c.flow_max == a) ? b : a;
          c.timeout_limit       = TimeoutW'($urandom_range(1, 40));
          c.rod_brake_threshold = RodW'($urandom);
        end
      endcase
      load_cfg(c);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (ph == 0 && n == 100) hold_req <= hold_req + 1;
        put_random();
      end
      drain();
    end

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
